[design/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared types and constants: beat payloads, status codes and the command
// group that runs from the controller to the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Number of entries the queue holds.
  localparam int unsigned QUEUE_DEPTH = 16;

  // Width of the entry count, wide enough to hold QUEUE_DEPTH itself.
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Fixed width of the occupancy field in a result beat.
  localparam int unsigned OCC_W = 5;

  // Word widths of the payload.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PRIO_W = 32;

  // Operation codes of the mode field.
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ENQUEUED  = 2'd0,
    ST_DEQUEUED  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } spq_status_e;

  // Request beat.
  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] data_in;
    logic signed [PRIO_W-1:0] priority_in;
  } spq_in_t;

  // Result beat.
  typedef struct packed {
    spq_status_e              status;
    logic signed [DATA_W-1:0] data_out;
    logic signed [PRIO_W-1:0] priority_out;
    logic [OCC_W-1:0]         occupancy;
  } spq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // Capture the request beat.
    logic exec;  // Apply the captured request and load the result register.
  } spq_cmd_t;

endpackage

[design/spq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue datapath
// Holds the sorted entry array, the entry count, the captured request and
// the result register. An insert compares every slot against the new
// priority in parallel and shifts the tail down by one slot; a removal
// shifts every slot up by one.
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spq_cmd_t cmd_i,
  input  spq_in_t  req_i,
  output spq_out_t result_o
);

  // Captured request, entry storage and count.
  spq_in_t                  req_q;
  logic signed [DATA_W-1:0] data_q [QUEUE_DEPTH];
  logic signed [PRIO_W-1:0] prio_q [QUEUE_DEPTH];
  logic signed [DATA_W-1:0] data_d [QUEUE_DEPTH];
  logic signed [PRIO_W-1:0] prio_d [QUEUE_DEPTH];
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         count_d;
  spq_out_t                 res_q;
  spq_out_t                 res_d;

  // Per-slot compare results; le_ext has an always-true entry above slot 0.
  logic [QUEUE_DEPTH-1:0]   le;
  logic [QUEUE_DEPTH-1:0]   le_ext;
  logic                     full;
  logic                     empty;
  logic                     is_deq;
  logic                     wr_en;

  // Slot i holds a stored entry whose priority does not exceed the new one.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le[i] = (CNT_W'(i) < count_q) && (prio_q[i] <= req_q.priority_in);
    end
    le_ext = {le[QUEUE_DEPTH-2:0], 1'b1};
  end

  assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);
  assign is_deq = (req_q.mode == MODE_DEQ);
  assign wr_en  = cmd_i.exec && (is_deq ? !empty : !full);

  // Next contents of every slot for the captured operation.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      data_d[i] = data_q[i];
      prio_d[i] = prio_q[i];
    end
    if (is_deq) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        data_d[i] = data_q[i+1];
        prio_d[i] = prio_q[i+1];
      end
    end else begin
      // Slots that stay ahead keep their entry, the first slot behind them
      // takes the new entry, and the rest take the entry one slot above.
      if (!le[0]) begin
        data_d[0] = req_q.data_in;
        prio_d[0] = req_q.priority_in;
      end
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (!le[i]) begin
          if (le_ext[i]) begin
            data_d[i] = req_q.data_in;
            prio_d[i] = req_q.priority_in;
          end else begin
            data_d[i] = data_q[i-1];
            prio_d[i] = prio_q[i-1];
          end
        end
      end
    end
  end

  // Next count and the result beat.
  always_comb begin
    count_d = count_q;
    res_d   = '0;
    if (is_deq) begin
      if (empty) begin
        res_d.status = ST_UNDERFLOW;
      end else begin
        count_d            = count_q - CNT_W'(1);
        res_d.status       = ST_DEQUEUED;
        res_d.data_out     = data_q[0];
        res_d.priority_out = prio_q[0];
      end
    end else begin
      if (full) begin
        res_d.status = ST_OVERFLOW;
      end else begin
        count_d      = count_q + CNT_W'(1);
        res_d.status = ST_ENQUEUED;
      end
    end
    res_d.occupancy = OCC_W'(count_d);
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (wr_en) begin
      count_q <= count_d;
    end
  end

  // Payload registers: request, entries and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (wr_en) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        data_q[i] <= data_d[i];
        prio_q[i] <= prio_d[i];
      end
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

  // The count never exceeds the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // The two most urgent entries stay in order.
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (prio_q[0] <= prio_q[1]))
    else $error("head entries out of priority order");

  // A removal from a non-empty queue lowers the count by one.
  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_deq && !empty) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("dequeue did not decrement the count");

endmodule

[design/spq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue controller
// Two-state sequencer: takes a request beat, then applies it to the
// datapath once the result register is free, and drives the handshakes.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spq_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   out_free;

  // The result register can be loaded when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;
  assign cmd_o    = '{load: in_valid_i && in_ready_q,
                      exec: (state_q == S_EXEC) && out_free};

  // State and registered handshake outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          // A waiting result leaves when the receiver takes it.
          if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_valid_i) begin
            state_q    <= S_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          // The new result replaces the old one in the same cycle it drains.
          if (out_free) begin
            state_q     <= S_IDLE;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  // Ready is offered exactly while no request is in flight.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_q == (state_q == S_IDLE))
    else $error("input ready disagrees with controller state");

  // Every executed request presents a result on the next cycle.
  a_exec_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_q)
    else $error("executed request produced no result");

  // A request waits while the previous result is stalled.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && out_valid_q && !out_ready_i) |=> (state_q == S_EXEC))
    else $error("request applied over a stalled result");

endmodule

[design/stable_priority_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue unit
// Bounded queue of data and priority pairs, kept sorted by priority with
// arrival order among equals. Each request is an enqueue or a dequeue and
// returns exactly one result beat.
// ----------------------------------------------------------------------------
//  Channel  Signals                           Beat contents
//  in       in_valid_i / in_ready_o / in_data_i    mode, data_in, priority_in
//  out      out_valid_o / out_ready_i / out_data_o status, data_out,
//                                                  priority_out, occupancy
//
//  A request is first captured; then the parallel compare-and-shift over
//  all QUEUE_DEPTH slots runs and also loads the result register. Reset
//  empties the queue at once; no clearing pass. A request may be taken
//  while the previous result is still waiting; it is then held until the
//  result register is drained.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spq_out_t out_data_o
);

  spq_cmd_t cmd;

  // Sequencer.
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Entry storage and result formation.
  spq_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (in_data_i),
    .result_o (out_data_o)
  );

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue unit testbench
// Drives enqueue and dequeue beats into the queue and checks every result beat
// against a sorted-array model of the queue kept in the testbench. A short
// directed part covers the empty, full, extreme-priority and equal-priority
// cases. Random traffic follows, swinging between filling and draining,
// under several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  // Longest run of cycles without any accepted beat before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Cycles to wait after the last result.
  localparam int unsigned SETTLE_CYCLES = 8;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  spq_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  spq_out_t out_data_o;

  // Model of the queue contents, kept sorted with slot 0 at the head.
  logic signed [DATA_W-1:0] held_data [QUEUE_DEPTH];
  logic signed [PRIO_W-1:0] held_prio [QUEUE_DEPTH];
  int unsigned              held_count = 0;

  // Result beats predicted for accepted requests, oldest first.
  spq_out_t    pending_results [$];
  int unsigned error_count    = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  stable_priority_queue_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Free-running clock, 10 ns period.
  always #5 clk_i = ~clk_i;

  // Applies one request to the queue model and returns the result beat it
  // should produce.
  function automatic spq_out_t predict_queue_op(input spq_in_t req);
    spq_out_t    res;
    int unsigned pos;
    int unsigned i;
    res = '0;
    if (req.mode == MODE_ENQ) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        // The new entry goes behind every entry of equal or more urgent priority.
        pos = 0;
        while (pos < held_count && $signed(held_prio[pos]) <= $signed(req.priority_in))
          pos++;
        for (i = held_count; i > pos; i--) begin
          held_data[i] = held_data[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_data[pos] = req.data_in;
        held_prio[pos] = req.priority_in;
        held_count++;
        res.status = ST_ENQUEUED;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.status       = ST_DEQUEUED;
        res.data_out     = held_data[0];
        res.priority_out = held_prio[0];
        for (i = 1; i < held_count; i++) begin
          held_data[i-1] = held_data[i];
          held_prio[i-1] = held_prio[i];
        end
        held_count--;
      end
    end
    res.occupancy = OCC_W'(held_count);
    return res;
  endfunction

  function automatic spq_in_t make_beat(input logic mode, input logic signed [31:0] data,
                                        input logic signed [31:0] prio);
    spq_in_t beat;
    beat.mode        = mode;
    beat.data_in     = data;
    beat.priority_in = prio;
    return beat;
  endfunction

  // Random priority: mostly a narrow range so that ties are common, with
  // extremes and fully random words mixed in.
  function automatic logic signed [31:0] pick_priority();
    logic signed [31:0] prio;
    case ($urandom_range(9))
      0, 1, 2, 3: prio = $urandom_range(3);
      4, 5:       prio = $signed($urandom_range(16)) - 8;
      6: begin
        case ($urandom_range(5))
          0:       prio = 32'sh8000_0000;
          1:       prio = 32'sh7FFF_FFFF;
          2:       prio = 32'sh8000_0001;
          3:       prio = 32'sh7FFF_FFFE;
          4:       prio = 0;
          default: prio = -1;
        endcase
      end
      default:    prio = $urandom;
    endcase
    return prio;
  endfunction

  // Sends one request beat, with optional idle cycles before it, and records
  // the predicted result once the beat is accepted.
  task automatic send_beat(input spq_in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(predict_queue_op(beat));
  endtask

  // Dequeue on an empty queue must report underflow.
  task automatic test_empty_dequeue();
    send_beat(make_beat(MODE_DEQ, 32'sh7FFF_FFFF, 32'sh8000_0000));
  endtask

  // Entries at the extremes of the data and priority ranges.
  task automatic test_extreme_priorities();
    send_beat(make_beat(MODE_ENQ, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_beat(make_beat(MODE_ENQ, 32'sh8000_0000, 32'sh8000_0000));
    send_beat(make_beat(MODE_ENQ, 32'sh0000_0000, 32'sh0000_0000));
    send_beat(make_beat(MODE_ENQ, 32'shFFFF_FFFF, 32'shFFFF_FFFF));
  endtask

  // Entries of equal priority must leave in arrival order.
  task automatic test_equal_priority_order();
    send_beat(make_beat(MODE_ENQ, 32'sd100, 32'sd5));
    send_beat(make_beat(MODE_ENQ, 32'sd101, 32'sd5));
    send_beat(make_beat(MODE_ENQ, 32'sd102, 32'sd5));
  endtask

  // Fill the queue to the last slot, try to overfill it, then take some out.
  task automatic test_full_overflow();
    logic signed [31:0] fill_prio [9];
    int unsigned        k;
    fill_prio = '{5, -1, 0, 7, 5, 3, 5, 2, 5};
    for (k = 0; k < 9; k++)
      send_beat(make_beat(MODE_ENQ, 32'sh0A00_0000 + k, fill_prio[k]));
    send_beat(make_beat(MODE_ENQ, 32'sh5555_5555, 32'sh8000_0000));
    send_beat(make_beat(MODE_ENQ, 32'shAAAA_AAAA, 32'sd5));
    for (k = 0; k < 4; k++)
      send_beat(make_beat(MODE_DEQ, $urandom, $urandom));
  endtask

  // Random traffic that alternates between filling, draining and balanced
  // stretches, so that the queue runs into full and empty often.
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned n_beats);
    spq_in_t     beat;
    int unsigned enq_pct;
    int unsigned k;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    enq_pct        = 50;
    for (k = 0; k < n_beats; k++) begin
      if (k % 48 == 0) begin
        case ((k / 48) % 3)
          0:       enq_pct = 85;
          1:       enq_pct = 15;
          default: enq_pct = 50;
        endcase
      end
      beat.mode        = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
      beat.data_in     = $urandom;
      beat.priority_in = pick_priority();
      send_beat(beat);
    end
  endtask

  // Receiver: stalls at random at the current stall rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk_i) begin
    spq_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d data_out %0h priority_out %0h",
               out_data_o.status, out_data_o.data_out, out_data_o.priority_out);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
          error_count++;
        end
        if (out_data_o.data_out !== want.data_out) begin
          $error("data_out: expected %0h, actual %0h", want.data_out, out_data_o.data_out);
          error_count++;
        end
        if (out_data_o.priority_out !== want.priority_out) begin
          $error("priority_out: expected %0h, actual %0h",
                 want.priority_out, out_data_o.priority_out);
          error_count++;
        end
        if (out_data_o.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", want.occupancy, out_data_o.occupancy);
          error_count++;
        end
      end
    end
  end

  // Watchdog: abandon the run when no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL stable_priority_queue_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_dequeue();
    test_extreme_priorities();
    test_equal_priority_order();
    test_full_overflow();

    test_random_traffic(0, 0, 475);
    test_random_traffic(77, 0, 475);
    test_random_traffic(0, 77, 475);
    test_random_traffic(19, 19, 475);

    // Drain the remaining results, then give the block time to settle.
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS stable_priority_queue_unit");
    end else begin
      $display("FAIL stable_priority_queue_unit");
    end
    $finish;
  end

endmodule

[sim.f]
design/spq_pkg.sv
design/spq_datapath.sv
design/spq_ctrl.sv
design/stable_priority_queue_unit.sv
test/testbench.sv
